[hw/rtl/e2e_profile5_check_defines.svh]
// assertion macros for the e2e profile 5 check, used in the eval stage
`ifndef E2E_PROFILE5_CHECK_DEFINES_SVH
`define E2E_PROFILE5_CHECK_DEFINES_SVH

// condition holds in the same cycle
`define E2E5_ASSERT_IMPL(label, ck, rn, pre, post, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error(msg);

// condition holds in the following cycle
`define E2E5_ASSERT_NEXT(label, ck, rn, pre, post, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error(msg);

`endif

[hw/rtl/e2e5_pkg.sv]
package e2e5_pkg;

  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [9:0]  COUNT_MAX = 10'd1023;

  // configuration register indexes
  localparam logic [1:0] CFG_DATA_ID    = 2'd0;
  localparam logic [1:0] CFG_CRC_OFFSET = 2'd1;
  localparam logic [1:0] CFG_FRAME_LEN  = 2'd2;
  localparam logic [1:0] CFG_MAX_DELTA  = 2'd3;

  // profile status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OK_LOST   = 3'd1;
  localparam logic [2:0] ST_REPEATED  = 3'd2;
  localparam logic [2:0] ST_WRONG_SEQ = 3'd3;
  localparam logic [2:0] ST_CRC_ERR   = 3'd4;
  localparam logic [2:0] ST_NO_DATA   = 3'd5;

  // generic mapped status codes
  localparam logic [2:0] MS_OK        = 3'd0;
  localparam logic [2:0] MS_REPEATED  = 3'd1;
  localparam logic [2:0] MS_WRONG_SEQ = 3'd2;
  localparam logic [2:0] MS_ERROR     = 3'd3;
  localparam logic [2:0] MS_NO_DATA   = 3'd4;

  // summary of one finished frame (or a no-data transaction)
  typedef struct packed {
    logic        no_data;
    logic        len_bad;
    logic [15:0] crc;
    logic [15:0] rx_crc;
    logic [7:0]  counter;
  } e2e5_frame_t;

  typedef struct packed {
    logic [2:0] status;
    logic       call_error;
    logic [2:0] mapped;
    logic [7:0] counter;
  } e2e5_result_t;

  // crc-16 ccitt, one byte, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [2:0] map_status(input logic [2:0] s);
    logic [2:0] m;
    unique case (s) inside
      ST_OK, ST_OK_LOST: m = MS_OK;
      ST_REPEATED:       m = MS_REPEATED;
      ST_WRONG_SEQ:      m = MS_WRONG_SEQ;
      ST_NO_DATA:        m = MS_NO_DATA;
      default:           m = MS_ERROR;
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/e2e_profile5_check.sv]
// e2e profile 5 receive-side check
// input stream: one frame byte per transaction on in_tdata, in_tlast marks the
// final byte, in_tuser high means "no new data" (byte and last ignored, any
// partial frame is dropped). output stream: one status transaction per frame
// end or no-data transaction; bytes in the middle of a frame give none.
// throughput: one input transaction per cycle while in_tready is high, set by
// the bytewise crc update in the frame stage; the data id bytes are folded in
// over the two eval stages. a result reaches the output register by passing
// the input reg, the frame summary reg and the eval reg, in that order.
// a stalled out_tready holds the output register; the stages behind it keep
// taking frame bytes until three more finished frames wait behind it (eval,
// summary and input registers), then in_tready drops. config writes go
// straight to the registers and are meant for idle time.
// reset (rst_n low, synchronous) empties the pipeline, restores register
// defaults, last counter 255 and last status crc error.
module e2e_profile5_check #(
  parameter int MAX_FRAME_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  input  logic        in_tuser,   // [0] no_new_data
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [2:0] check_status, [3] call_error,
                                  // [6:4] mapped_status, [14:7] counter_seen, [15] zero
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] data_id_r;
  logic [8:0]  crc_offset_r;
  logic [9:0]  frame_len_r;
  logic [6:0]  max_delta_r;

  logic                   sum_valid, sum_ready;
  e2e5_pkg::e2e5_frame_t  sum;
  e2e5_pkg::e2e5_result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_id_r    <= 16'd0;
      crc_offset_r <= 9'd0;
      frame_len_r  <= 10'd3;
      max_delta_r  <= 7'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        e2e5_pkg::CFG_DATA_ID:    data_id_r    <= cfg_wdata;
        e2e5_pkg::CFG_CRC_OFFSET: crc_offset_r <= cfg_wdata[8:0];
        e2e5_pkg::CFG_FRAME_LEN:  frame_len_r  <= cfg_wdata[9:0];
        e2e5_pkg::CFG_MAX_DELTA:  max_delta_r  <= cfg_wdata[6:0];
        default:                  ;
      endcase
    end
  end

  // frame assembly: crc over payload, capture of crc and counter bytes
  e2e5_frame #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .in_no_data (in_tuser),
    .crc_offset (crc_offset_r),
    .frame_len  (frame_len_r),
    .sum_valid  (sum_valid),
    .sum_ready  (sum_ready),
    .sum        (sum)
  );

  // data id, crc compare, counter check, status and output register
  e2e5_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum),
    .data_id   (data_id_r),
    .max_delta (max_delta_r),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {1'b0, res.counter, res.mapped, res.call_error, res.status};

endmodule

[hw/rtl/e2e5_frame.sv]
module e2e5_frame #(
  parameter int MAX_FRAME_BYTES = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  logic                 in_no_data,
  input  logic [8:0]           crc_offset,
  input  logic [9:0]           frame_len,
  output logic                 sum_valid,
  input  logic                 sum_ready,
  output e2e5_pkg::e2e5_frame_t sum
);

  localparam int LEN_W = ($clog2(MAX_FRAME_BYTES + 1) > 11) ?
                         $clog2(MAX_FRAME_BYTES + 1) : 11;

  logic        s1_v_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        s1_no_data_r;
  logic        sum_v_r;
  e2e5_pkg::e2e5_frame_t sum_r;

  logic [15:0] running_crc_r, running_crc_nxt;
  logic [9:0]  byte_count_r, byte_count_nxt;
  logic [15:0] rx_crc_r, rx_crc_nxt;
  logic [7:0]  counter_r, counter_nxt;

  logic        s1_res;
  logic        s1_fire;
  logic [9:0]  offset10;
  logic        hit_lo, hit_hi, hit_cnt;
  logic [LEN_W-1:0] len;
  logic        len_bad;

  assign s1_res   = s1_no_data_r | s1_last_r;
  assign s1_fire  = s1_v_r & (~s1_res | ~sum_v_r | sum_ready);
  assign in_ready = ~s1_v_r | s1_fire;

  assign offset10 = {1'b0, crc_offset};
  assign hit_lo   = (byte_count_r == offset10);
  assign hit_hi   = (byte_count_r == offset10 + 10'd1);
  assign hit_cnt  = (byte_count_r == offset10 + 10'd2);

  always_comb begin
    rx_crc_nxt      = rx_crc_r;
    counter_nxt     = counter_r;
    running_crc_nxt = running_crc_r;
    if (hit_lo) begin
      rx_crc_nxt[7:0] = s1_byte_r;
    end else if (hit_hi) begin
      rx_crc_nxt[15:8] = s1_byte_r;
    end else begin
      if (hit_cnt) begin
        counter_nxt = s1_byte_r;
      end
      running_crc_nxt = e2e5_pkg::crc_byte(running_crc_r, s1_byte_r);
    end
  end

  assign byte_count_nxt = (byte_count_r == e2e5_pkg::COUNT_MAX) ? byte_count_r :
                          byte_count_r + 10'd1;

  assign len     = LEN_W'(byte_count_r) + LEN_W'(1);
  assign len_bad = (len != LEN_W'(frame_len)) || (len > LEN_W'(MAX_FRAME_BYTES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r        <= 1'b0;
      sum_v_r       <= 1'b0;
      running_crc_r <= e2e5_pkg::CRC_START;
      byte_count_r  <= '0;
      rx_crc_r      <= '0;
      counter_r     <= '0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      sum_v_r <= (s1_fire & s1_res) | (sum_v_r & ~sum_ready);
      if (s1_fire) begin
        if (s1_res) begin
          // frame done or dropped: start over
          running_crc_r <= e2e5_pkg::CRC_START;
          byte_count_r  <= '0;
          rx_crc_r      <= '0;
          counter_r     <= '0;
        end else begin
          running_crc_r <= running_crc_nxt;
          byte_count_r  <= byte_count_nxt;
          rx_crc_r      <= rx_crc_nxt;
          counter_r     <= counter_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid & in_ready) begin
      s1_byte_r    <= in_byte;
      s1_last_r    <= in_last;
      s1_no_data_r <= in_no_data;
    end
    if (s1_fire & s1_res) begin
      sum_r.no_data <= s1_no_data_r;
      sum_r.len_bad <= len_bad;
      sum_r.crc     <= running_crc_nxt;
      sum_r.rx_crc  <= rx_crc_nxt;
      sum_r.counter <= counter_nxt;
    end
  end

  assign sum_valid = sum_v_r;
  assign sum       = sum_r;

endmodule

[hw/rtl/e2e5_eval.sv]
`include "e2e_profile5_check_defines.svh"

module e2e5_eval (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  sum_valid,
  output logic                  sum_ready,
  input  e2e5_pkg::e2e5_frame_t sum,
  input  logic [15:0]           data_id,
  input  logic [6:0]            max_delta,
  output logic                  res_valid,
  input  logic                  res_ready,
  output e2e5_pkg::e2e5_result_t res
);

  logic                   mid_v_r;
  e2e5_pkg::e2e5_frame_t  mid_r;
  logic                   res_v_r;
  e2e5_pkg::e2e5_result_t res_r, res_nxt;
  logic [7:0]             last_counter_r, last_counter_nxt;
  logic [2:0]             last_status_r, last_status_nxt;

  logic       out_free, mid_free, mid_fire;
  logic [15:0] crc_fin;
  logic       crc_ok;
  logic [7:0] delta;
  logic [2:0] status;

  assign out_free  = ~res_v_r | res_ready;
  assign mid_fire  = mid_v_r & out_free;
  assign mid_free  = ~mid_v_r | out_free;
  assign sum_ready = mid_free;

  assign crc_fin = e2e5_pkg::crc_byte(mid_r.crc, data_id[15:8]);
  assign crc_ok  = (crc_fin == mid_r.rx_crc);
  assign delta   = mid_r.counter - last_counter_r;

  always_comb begin
    if (!crc_ok) begin
      status = e2e5_pkg::ST_CRC_ERR;
    end else if (delta[7] || (delta > {1'b0, max_delta})) begin
      status = e2e5_pkg::ST_WRONG_SEQ;
    end else if (delta == 8'd0) begin
      status = e2e5_pkg::ST_REPEATED;
    end else if (delta == 8'd1) begin
      status = e2e5_pkg::ST_OK;
    end else begin
      status = e2e5_pkg::ST_OK_LOST;
    end
  end

  always_comb begin
    last_counter_nxt = last_counter_r;
    last_status_nxt  = last_status_r;
    if (mid_r.no_data) begin
      res_nxt.status     = e2e5_pkg::ST_NO_DATA;
      res_nxt.call_error = 1'b0;
      res_nxt.mapped     = e2e5_pkg::MS_NO_DATA;
      res_nxt.counter    = 8'd0;
      last_status_nxt    = e2e5_pkg::ST_NO_DATA;
    end else if (mid_r.len_bad) begin
      res_nxt.status     = last_status_r;
      res_nxt.call_error = 1'b1;
      res_nxt.mapped     = e2e5_pkg::MS_ERROR;
      res_nxt.counter    = mid_r.counter;
    end else begin
      res_nxt.status     = status;
      res_nxt.call_error = 1'b0;
      res_nxt.mapped     = e2e5_pkg::map_status(status);
      res_nxt.counter    = mid_r.counter;
      last_status_nxt    = status;
      if (crc_ok) begin
        last_counter_nxt = mid_r.counter;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_v_r        <= 1'b0;
      res_v_r        <= 1'b0;
      last_counter_r <= 8'hFF;
      last_status_r  <= e2e5_pkg::ST_CRC_ERR;
    end else begin
      if (mid_free) begin
        mid_v_r <= sum_valid;
      end
      if (out_free) begin
        res_v_r <= mid_v_r;
      end
      if (mid_fire) begin
        last_counter_r <= last_counter_nxt;
        last_status_r  <= last_status_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid & mid_free) begin
      mid_r     <= sum;
      // low byte of the data id goes in here, high byte in the next stage
      mid_r.crc <= e2e5_pkg::crc_byte(sum.crc, data_id[7:0]);
    end
    if (mid_fire) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_v_r;
  assign res       = res_r;

  `E2E5_ASSERT_IMPL(a_call_err_map, clk, rst_n, res_v_r && res_r.call_error,
                    res_r.mapped == e2e5_pkg::MS_ERROR, "call error without error mapping")
  `E2E5_ASSERT_NEXT(a_counter_upd, clk, rst_n,
                    mid_fire && !mid_r.no_data && !mid_r.len_bad && crc_ok,
                    last_counter_r == $past(mid_r.counter), "counter not stored")
  `E2E5_ASSERT_NEXT(a_no_data_res, clk, rst_n, mid_fire && mid_r.no_data,
                    res_v_r && (res_r.status == e2e5_pkg::ST_NO_DATA) && (res_r.counter == 8'd0),
                    "no-data result malformed")
  `E2E5_ASSERT_NEXT(a_len_bad_hold, clk, rst_n, mid_fire && !mid_r.no_data && mid_r.len_bad,
                    $stable(last_counter_r) && $stable(last_status_r),
                    "wrong length changed state")

endmodule

[dv/e2e_profile5_check_tb.sv]
`timescale 1ns / 1ps

module e2e_profile5_check_tb;

  // crc-16 ccitt, msb first, no final xor
  localparam logic [15:0] CCITT_SEED = 16'hFFFF;
  localparam logic [15:0] CCITT_POLY = 16'h1021;
  localparam int          FRAME_CAP  = 512;
  localparam int          COUNT_SAT  = 1023;

  // one status transaction, field by field
  typedef struct packed {
    logic [2:0] status;
    logic       call_err;
    logic [2:0] mapped;
    logic [7:0] counter;
  } frame_status_t;

  // tracks the receive-side check and holds the status transactions still owed
  class frame_status_board;
    logic [15:0]   data_id;
    logic [8:0]    crc_off;
    logic [9:0]    frame_len;
    logic [6:0]    max_delta;
    logic [7:0]    last_cnt;
    logic [2:0]    last_st;
    logic [15:0]   run_crc;
    logic [9:0]    nbytes;
    logic [15:0]   rx_crc;
    logic [7:0]    rx_cnt;
    frame_status_t pending_status[$];
    int            errors;

    function new();
      data_id   = '0;
      crc_off   = '0;
      frame_len = 10'd3;
      max_delta = 7'd1;
      last_cnt  = 8'hFF;
      last_st   = e2e5_pkg::ST_CRC_ERR;
      errors    = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      run_crc = CCITT_SEED;
      nbytes  = '0;
      rx_crc  = '0;
      rx_cnt  = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        e2e5_pkg::CFG_DATA_ID:    data_id   = val;
        e2e5_pkg::CFG_CRC_OFFSET: crc_off   = val[8:0];
        e2e5_pkg::CFG_FRAME_LEN:  frame_len = val[9:0];
        e2e5_pkg::CFG_MAX_DELTA:  max_delta = val[6:0];
        default: ;
      endcase
    endfunction

    // bit-serial form: feedback is crc msb xor data bit
    function logic [15:0] ccitt_update(logic [15:0] c, logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ d[i];
        c  = {c[14:0], 1'b0};
        if (fb) c = c ^ CCITT_POLY;
      end
      return c;
    endfunction

    function logic [2:0] generic_of(logic [2:0] s);
      case (s) inside
        e2e5_pkg::ST_OK, e2e5_pkg::ST_OK_LOST: return e2e5_pkg::MS_OK;
        e2e5_pkg::ST_REPEATED:                 return e2e5_pkg::MS_REPEATED;
        e2e5_pkg::ST_WRONG_SEQ:                return e2e5_pkg::MS_WRONG_SEQ;
        e2e5_pkg::ST_NO_DATA:                  return e2e5_pkg::MS_NO_DATA;
        default:                               return e2e5_pkg::MS_ERROR;
      endcase
    endfunction

    // one accepted input transaction
    function void take_item(logic [7:0] b, logic last, logic nd);
      frame_status_t r;
      int            pos;
      logic [15:0]   c;
      logic [7:0]    delta;
      if (nd) begin
        restart_frame();
        last_st    = e2e5_pkg::ST_NO_DATA;
        r.status   = e2e5_pkg::ST_NO_DATA;
        r.call_err = 1'b0;
        r.mapped   = e2e5_pkg::MS_NO_DATA;
        r.counter  = '0;
        pending_status.push_back(r);
        return;
      end
      pos = int'(nbytes);
      if (pos == int'(crc_off)) begin
        rx_crc[7:0] = b;
      end else if (pos == int'(crc_off) + 1) begin
        rx_crc[15:8] = b;
      end else begin
        if (pos == int'(crc_off) + 2) rx_cnt = b;
        run_crc = ccitt_update(run_crc, b);
      end
      if (pos < COUNT_SAT) nbytes = nbytes + 10'd1;
      if (!last) return;

      r.counter = rx_cnt;
      if (pos + 1 != int'(frame_len) || pos + 1 > FRAME_CAP) begin
        // length error: history untouched, old status reported
        r.status   = last_st;
        r.call_err = 1'b1;
        r.mapped   = e2e5_pkg::MS_ERROR;
      end else begin
        c = ccitt_update(run_crc, data_id[7:0]);
        c = ccitt_update(c, data_id[15:8]);
        if (c == rx_crc) begin
          delta = rx_cnt - last_cnt;
          if (delta <= {1'b0, max_delta} && !delta[7]) begin
            if (delta == 8'd0)      r.status = e2e5_pkg::ST_REPEATED;
            else if (delta == 8'd1) r.status = e2e5_pkg::ST_OK;
            else                    r.status = e2e5_pkg::ST_OK_LOST;
          end else begin
            r.status = e2e5_pkg::ST_WRONG_SEQ;
          end
          last_cnt = rx_cnt;
        end else begin
          r.status = e2e5_pkg::ST_CRC_ERR;
        end
        last_st    = r.status;
        r.call_err = 1'b0;
        r.mapped   = generic_of(r.status);
      end
      pending_status.push_back(r);
      restart_frame();
    endfunction

    function void note_fail(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    // one accepted status transaction
    function void match_status(logic [15:0] d);
      frame_status_t want;
      frame_status_t got;
      got.status   = d[2:0];
      got.call_err = d[3];
      got.mapped   = d[6:4];
      got.counter  = d[14:7];
      if (pending_status.size() == 0) begin
        note_fail($sformatf("status transaction with nothing pending, tdata %h", d));
        return;
      end
      want = pending_status.pop_front();
      if (got.status != want.status)
        note_fail($sformatf("check_status exp %0d got %0d", want.status, got.status));
      if (got.call_err != want.call_err)
        note_fail($sformatf("call_error exp %0d got %0d", want.call_err, got.call_err));
      if (got.mapped != want.mapped)
        note_fail($sformatf("mapped_status exp %0d got %0d", want.mapped, got.mapped));
      if (got.counter != want.counter)
        note_fail($sformatf("counter_seen exp %h got %h", want.counter, got.counter));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  frame_status_board sb;
  int idle_pct = 36;   // chance in percent of an idle cycle, both sides
  int items    = 0;    // accepted input transactions
  bit hold_req = 1'b0; // asks the receiver for one long hold-off

  e2e_profile5_check dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // receiver: random backpressure plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        hold_left  = 199;
        out_tready = 1'b0;
      end else begin
        out_tready = ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // every status transaction is checked at the edge that takes it
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.match_status(out_tdata);
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_item(input logic [7:0] b, input logic l, input logic nd);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = l;
    in_tuser  = nd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_item(b, l, nd);
    items++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic configure(input logic [15:0] id, input int off, input int len,
                           input int md);
    write_reg(e2e5_pkg::CFG_DATA_ID, id);
    write_reg(e2e5_pkg::CFG_CRC_OFFSET, 16'(off));
    write_reg(e2e5_pkg::CFG_FRAME_LEN, 16'(len));
    write_reg(e2e5_pkg::CFG_MAX_DELTA, 16'(md));
  endtask

  // wait for every owed status, then let the pipeline run empty
  task automatic settle();
    int guard;
    guard     = 0;
    in_tvalid = 1'b0;
    while (sb.pending_status.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  // a frame sealed with the current data id and crc offset;
  // corrupt flips one bit, an open frame is dropped by a no-data transaction
  task automatic send_frame(input int len, input logic [7:0] cnt, input bit corrupt,
                            input bit close);
    logic [7:0]  fb[];
    logic [15:0] c;
    int          off;
    int          k;
    fb  = new[len];
    off = int'(sb.crc_off);
    foreach (fb[i]) fb[i] = 8'($urandom);
    if (off + 2 < len) fb[off + 2] = cnt;
    c = CCITT_SEED;
    for (int i = 0; i < len; i++) begin
      if (i != off && i != off + 1) c = sb.ccitt_update(c, fb[i]);
    end
    c = sb.ccitt_update(c, sb.data_id[7:0]);
    c = sb.ccitt_update(c, sb.data_id[15:8]);
    if (off < len) fb[off] = c[7:0];
    if (off + 1 < len) fb[off + 1] = c[15:8];
    if (corrupt) begin
      k     = $urandom_range(len - 1);
      fb[k] = fb[k] ^ (8'h01 << $urandom_range(7));
    end
    for (int i = 0; i < len; i++) send_item(fb[i], close && (i == len - 1), 1'b0);
    if (!close) send_item(8'($urandom), 1'($urandom), 1'b1);
  endtask

  // counter advance: most often in sequence, plus repeats, jumps and backward steps
  function automatic logic [7:0] pick_counter();
    logic [7:0] base;
    base = sb.last_cnt;
    case ($urandom_range(9))
      0, 1, 2, 3: return base + 8'd1;
      4:          return base;
      5, 6:       return base + 8'($urandom_range(2, int'(sb.max_delta) + 2));
      7:          return base + 8'($urandom_range(128, 255));
      default:    return 8'($urandom);
    endcase
  endfunction

  initial begin
    int r;
    int n;
    int budget;
    int off;
    int len;
    int md;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset settings: offset 0, 3-byte frames, max delta 1
    send_frame(3, 8'h00, 0, 1);          // 255 -> 0 wraps to a step of one
    send_frame(3, 8'h00, 0, 1);          // repeated counter
    send_frame(3, 8'h02, 0, 1);          // step beyond max delta
    send_frame(3, 8'hFF, 1, 1);          // crc error
    send_frame(2, 8'h00, 0, 1);          // short frame, call error
    send_item(8'hFF, 1'b1, 1'b1);        // no new data
    send_frame(1, 8'h00, 0, 0);          // partial frame dropped by no data
    settle();
    configure(16'hFFFF, 0, 3, 127);
    send_frame(3, sb.last_cnt + 8'd5, 0, 1);    // some lost
    send_frame(3, sb.last_cnt + 8'd128, 0, 1);  // negative step
    settle();

    for (int p = 0; p < 8; p++) begin
      if (p == 1) begin
        // largest offset that keeps crc and counter in the frame, largest length, then a short frame
        configure(16'h0000, 509, 512, 0);
        send_frame(512, sb.last_cnt + 8'd1, 0, 1);
        send_frame(3, 8'h00, 0, 1);
        settle();
        continue;
      end
      if (p == 0) begin
        configure(16'hFFFF, 0, 3, 127);
        hold_req = 1'b1;   // back up the pipeline while 3-byte frames keep coming
      end else begin
        off = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 12);
        len = ($urandom_range(4) == 0) ? $urandom_range(3, 16)
                                       : off + 3 + $urandom_range(0, 6);
        case (p % 3)
          0:       md = 0;
          1:       md = 127;
          default: md = $urandom_range(0, 127);
        endcase
        configure(16'($urandom), off, len, md);
      end
      idle_pct = (p == 2) ? 0 : 36;  // one phase runs with no gaps at all
      budget   = items + 40;
      while (items < budget) begin
        r = $urandom_range(99);
        if (r < 68) begin
          send_frame(int'(sb.frame_len), pick_counter(), $urandom_range(9) == 0, 1);
        end else if (r < 78) begin
          n = $urandom_range(1, int'(sb.frame_len) + 4);
          if (n == int'(sb.frame_len)) n++;
          send_frame(n, pick_counter(), 0, 1);
        end else if (r < 88) begin
          send_item(8'($urandom), 1'($urandom), 1'b1);
        end else begin
          send_frame($urandom_range(1, int'(sb.frame_len)), pick_counter(), 0, 0);
        end
      end
      settle();
    end
    idle_pct = 36;

    if (sb.pending_status.size() != 0)
      sb.note_fail($sformatf("%0d status transactions never arrived",
                             sb.pending_status.size()));
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
